FILE: rtl/vfrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vfrd_pkg;

  // Frame limits. A length byte must be below LEN_LIMIT (at most 64, so it fits 6 bits).
  localparam int LEN_LIMIT   = 50;
  // Saturation point of the trust counter (at most 31, so it fits 5 bits).
  localparam int TRUST_LIMIT = 20;
  // Number of payload bytes that are kept.
  localparam int NUM_KEPT    = 5;

  // Header and task codes.
  localparam logic [7:0] SOF_FIRST       = 8'hFF;
  localparam logic [7:0] SOF_SECOND      = 8'hFC;
  localparam logic [7:0] TASK_START      = 8'hA1;
  localparam logic [7:0] TASK_TRACK_LINE = 8'hA2;
  localparam logic [7:0] TASK_TRACK      = 8'hA3;

  // Camera identity that enables decoding.
  localparam logic [7:0] ENABLED_ID = 8'd1;

  // Configuration register indexes.
  localparam logic CFG_CAMERA_ID = 1'b0;
  localparam logic CFG_FALLBACK  = 1'b1;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC,
    PH_TASK,
    PH_LEN,
    PH_DATA,
    PH_SUM
  } phase_t;

  // One complete frame as seen by the decoder.
  typedef struct packed {
    logic [7:0]                   task_code;
    logic [NUM_KEPT-1:0][7:0]     bytes;
  } frame_t;

  // Held decoder results, shown on the result channel.
  typedef struct packed {
    logic signed [4:0] line_position;
    logic [15:0]       line_pattern;
    logic [7:0]        cross_code;
    logic [7:0]        detect_flag;
    logic [7:0]        frame_rate;
    logic [7:0]        control_enable;
    logic              trusted;
    logic [7:0]        start_result;
    logic [7:0]        track_result;
    logic [15:0]       lost_count;
  } held_t;

endpackage

`default_nettype wire

FILE: rtl/vfrd_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module vfrd_decode #(
  parameter int TRUST_LIMIT = vfrd_pkg::TRUST_LIMIT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              dec_en,
  input  wire vfrd_pkg::frame_t  frame,
  input  wire logic signed [4:0] fallback_position,
  output vfrd_pkg::held_t        held
);

  vfrd_pkg::held_t held_r;
  vfrd_pkg::held_t held_nxt;
  logic [4:0]      trust_r;
  logic [4:0]      trust_nxt;

  logic [15:0]       pattern;
  logic              map_ok;
  logic signed [4:0] map_pos;
  logic [7:0]        det_sel;
  logic [4:0]        trust_upd;
  logic              flag_upd;

  assign pattern = {frame.bytes[0], frame.bytes[1]};

  // Map a line pattern with one set bit or two adjacent set bits to a position.
  always_comb begin
    map_ok  = 1'b0;
    map_pos = '0;
    for (int i = 0; i < 16; i++) begin
      if (pattern == 16'(1 << i)) begin
        map_ok  = 1'b1;
        map_pos = 5'(2 * i - 15);
      end
    end
    for (int i = 0; i < 15; i++) begin
      if (pattern == 16'(3 << i)) begin
        map_ok  = 1'b1;
        map_pos = 5'(2 * i - 14);
      end
    end
  end

  // Trust update. The line-tracking task refreshes the detection byte before it is used.
  always_comb begin
    det_sel = (frame.task_code == vfrd_pkg::TASK_TRACK_LINE) ? frame.bytes[3]
                                                             : held_r.detect_flag;
    if (det_sel != 8'd0) begin
      if (trust_r < 5'(TRUST_LIMIT)) begin
        trust_upd = trust_r + 5'd1;
        flag_upd  = 1'b0;
      end else begin
        trust_upd = trust_r;
        flag_upd  = 1'b1;
      end
    end else begin
      trust_upd = trust_r >> 1;
      flag_upd  = 1'b0;
    end
  end

  // Decode a good frame by its task.
  always_comb begin
    held_nxt  = held_r;
    trust_nxt = trust_r;
    if (dec_en) begin
      case (frame.task_code)
        vfrd_pkg::TASK_TRACK_LINE: begin
          held_nxt.line_pattern   = pattern;
          held_nxt.cross_code     = frame.bytes[2];
          held_nxt.detect_flag    = frame.bytes[3];
          held_nxt.frame_rate     = frame.bytes[4];
          held_nxt.control_enable = frame.bytes[3];
          held_nxt.trusted        = flag_upd;
          trust_nxt               = trust_upd;
          if (map_ok) begin
            held_nxt.line_position = map_pos;
            held_nxt.lost_count    = held_r.lost_count >> 1;
          end else begin
            held_nxt.line_position = fallback_position;
            if (held_r.lost_count != 16'hFFFF) begin
              held_nxt.lost_count = held_r.lost_count + 16'd1;
            end
          end
        end
        vfrd_pkg::TASK_START: begin
          held_nxt.control_enable = held_r.detect_flag;
          held_nxt.trusted        = flag_upd;
          trust_nxt               = trust_upd;
          held_nxt.start_result   = frame.bytes[0];
        end
        vfrd_pkg::TASK_TRACK: begin
          held_nxt.trusted        = flag_upd;
          trust_nxt               = trust_upd;
          held_nxt.track_result   = frame.bytes[0];
        end
        default: begin
          held_nxt.control_enable = 8'd0;
          held_nxt.trusted        = 1'b0;
          held_nxt.line_pattern   = 16'd0;
        end
      endcase
    end
  end

  // Held state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      trust_r <= '0;
    end else begin
      held_r  <= held_nxt;
      trust_r <= trust_nxt;
    end
  end

  assign held = held_r;

  // The trust counter never passes its limit.
  a_trust_bound: assert property (@(posedge clk) disable iff (!rst_n)
    trust_r <= 5'(TRUST_LIMIT))
    else $error("trust counter above limit");

  // An unknown task clears control enable, the trust flag and the pattern.
  a_unknown_task: assert property (@(posedge clk) disable iff (!rst_n)
    dec_en && frame.task_code != vfrd_pkg::TASK_START
           && frame.task_code != vfrd_pkg::TASK_TRACK_LINE
           && frame.task_code != vfrd_pkg::TASK_TRACK
    |=> held_r.control_enable == 8'd0 && !held_r.trusted && held_r.line_pattern == 16'd0)
    else $error("unknown task did not clear decoder outputs");

endmodule

`default_nettype wire

FILE: rtl/vision_frame_receiver_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one received byte per cycle while in_ready is high.
// Latency: the result of a frame is valid in the cycle after its checksum byte is accepted.
// The input stalls only on a checksum byte while an earlier result still waits to be taken.
// Reset (synchronous, active low) returns the parser to waiting for a header, clears all
// held results and counters, and sets the camera id to 1 and the fallback position to 0.
module vision_frame_receiver_decoder #(
  parameter int LEN_LIMIT   = vfrd_pkg::LEN_LIMIT,
  parameter int TRUST_LIMIT = vfrd_pkg::TRUST_LIMIT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Configuration write port.
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [7:0]        cfg_data,
  // Received bytes.
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_rx_byte,
  // Decoded frames.
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_task_code,
  output logic signed [4:0]      out_line_position,
  output logic [15:0]            out_line_pattern,
  output logic [7:0]             out_cross_code,
  output logic [7:0]             out_detect_flag,
  output logic [7:0]             out_frame_rate,
  output logic [7:0]             out_control_enable,
  output logic                   out_trusted,
  output logic [7:0]             out_start_result,
  output logic [7:0]             out_track_result,
  output logic [15:0]            out_lost_count
);

  vfrd_pkg::phase_t phase_r;
  vfrd_pkg::phase_t phase_nxt;

  logic [7:0]        camera_id_r;
  logic signed [4:0] fallback_r;

  logic [5:0]        remaining_r;
  logic [5:0]        remaining_nxt;
  logic [5:0]        count_r;
  logic [5:0]        count_nxt;
  logic [7:0]        sum_r;
  logic [7:0]        sum_nxt;
  logic [7:0]        task_r;
  logic [7:0]        task_nxt;
  logic [vfrd_pkg::NUM_KEPT-1:0][7:0] bytes_r;
  logic [vfrd_pkg::NUM_KEPT-1:0][7:0] bytes_nxt;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [7:0]        out_task_r;

  logic              in_fire;
  logic              sum_hit;
  logic              dec_en;
  vfrd_pkg::frame_t  frame;
  vfrd_pkg::held_t   held;

  // A checksum byte waits while an untaken result occupies the output register.
  assign in_ready = !(phase_r == vfrd_pkg::PH_SUM && out_valid_r && !out_ready);
  assign in_fire  = in_valid && in_ready;

  // Parser next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      case (phase_r)
        vfrd_pkg::PH_IDLE: begin
          phase_nxt = (in_rx_byte == vfrd_pkg::SOF_FIRST) ? vfrd_pkg::PH_SYNC
                                                          : vfrd_pkg::PH_IDLE;
        end
        vfrd_pkg::PH_SYNC: begin
          phase_nxt = (in_rx_byte == vfrd_pkg::SOF_SECOND) ? vfrd_pkg::PH_TASK
                                                           : vfrd_pkg::PH_IDLE;
        end
        vfrd_pkg::PH_TASK: begin
          phase_nxt = (in_rx_byte != 8'hFF) ? vfrd_pkg::PH_LEN : vfrd_pkg::PH_IDLE;
        end
        vfrd_pkg::PH_LEN: begin
          phase_nxt = (in_rx_byte < 8'(LEN_LIMIT)) ? vfrd_pkg::PH_DATA
                                                   : vfrd_pkg::PH_IDLE;
        end
        vfrd_pkg::PH_DATA: begin
          if (remaining_r == 6'd0) begin
            phase_nxt = vfrd_pkg::PH_IDLE;
          end else if (remaining_r == 6'd1) begin
            phase_nxt = vfrd_pkg::PH_SUM;
          end else begin
            phase_nxt = vfrd_pkg::PH_DATA;
          end
        end
        default: begin
          phase_nxt = vfrd_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Parser datapath: checksum, task, length and kept payload bytes.
  always_comb begin
    sum_nxt       = sum_r;
    task_nxt      = task_r;
    remaining_nxt = remaining_r;
    count_nxt     = count_r;
    bytes_nxt     = bytes_r;
    if (in_fire) begin
      case (phase_r)
        vfrd_pkg::PH_IDLE: begin
          sum_nxt = in_rx_byte;
        end
        vfrd_pkg::PH_SYNC: begin
          sum_nxt = sum_r + in_rx_byte;
        end
        vfrd_pkg::PH_TASK: begin
          sum_nxt  = sum_r + in_rx_byte;
          if (in_rx_byte != 8'hFF) begin
            task_nxt = in_rx_byte;
          end
        end
        vfrd_pkg::PH_LEN: begin
          sum_nxt = sum_r + in_rx_byte;
          if (in_rx_byte < 8'(LEN_LIMIT)) begin
            remaining_nxt = in_rx_byte[5:0];
            count_nxt     = 6'd0;
          end
        end
        vfrd_pkg::PH_DATA: begin
          if (remaining_r != 6'd0) begin
            sum_nxt       = sum_r + in_rx_byte;
            remaining_nxt = remaining_r - 6'd1;
            count_nxt     = count_r + 6'd1;
            if (count_r < 6'(vfrd_pkg::NUM_KEPT)) begin
              bytes_nxt[count_r[2:0]] = in_rx_byte;
            end
          end
        end
        default: begin
          sum_nxt = sum_r;
        end
      endcase
    end
  end

  // A frame whose checksum matches gives a result; decoding needs the enabled camera id.
  assign sum_hit       = in_fire && phase_r == vfrd_pkg::PH_SUM && sum_r == in_rx_byte;
  assign dec_en        = sum_hit && camera_id_r == vfrd_pkg::ENABLED_ID;
  assign out_valid_nxt = sum_hit || (out_valid_r && !out_ready);

  assign frame.task_code = task_r;
  assign frame.bytes     = bytes_r;

  vfrd_decode #(
    .TRUST_LIMIT (TRUST_LIMIT)
  ) u_decode (
    .clk               (clk),
    .rst_n             (rst_n),
    .dec_en            (dec_en),
    .frame             (frame),
    .fallback_position (fallback_r),
    .held              (held)
  );

  // Control and parser registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= vfrd_pkg::PH_IDLE;
      remaining_r <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      task_r      <= '0;
      bytes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      task_r      <= task_nxt;
      bytes_r     <= bytes_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Task code of the pending result.
  always_ff @(posedge clk) begin
    if (sum_hit) begin
      out_task_r <= task_r;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      camera_id_r <= vfrd_pkg::ENABLED_ID;
      fallback_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vfrd_pkg::CFG_CAMERA_ID: camera_id_r <= cfg_data;
        vfrd_pkg::CFG_FALLBACK:  fallback_r  <= cfg_data[4:0];
        default:                 camera_id_r <= camera_id_r;
      endcase
    end
  end

  // Result outputs; held values change only when a new result is loaded.
  assign out_valid          = out_valid_r;
  assign out_task_code      = out_task_r;
  assign out_line_position  = held.line_position;
  assign out_line_pattern   = held.line_pattern;
  assign out_cross_code     = held.cross_code;
  assign out_detect_flag    = held.detect_flag;
  assign out_frame_rate     = held.frame_rate;
  assign out_control_enable = held.control_enable;
  assign out_trusted        = held.trusted;
  assign out_start_result   = held.start_result;
  assign out_track_result   = held.track_result;
  assign out_lost_count     = held.lost_count;

  // The input stalls only on a checksum byte behind a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> phase_r == vfrd_pkg::PH_SUM && out_valid_r)
    else $error("input stalled without a pending result");

  // A new result always shows up in the following cycle.
  a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
    sum_hit |=> out_valid_r)
    else $error("result lost");

  // The parser returns to waiting after every checksum byte.
  a_sum_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == vfrd_pkg::PH_SUM |=> phase_r == vfrd_pkg::PH_IDLE)
    else $error("parser did not return to waiting after checksum");

endmodule

`default_nettype wire
